[rtl/assert_macros.svh]
// Assertion macros for the RTL files; only aesctr_dpath includes them.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked on every clock edge outside reset.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication checked outside reset.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/aesctr_pkg.sv]
`default_nettype none
package aesctr_pkg;

    localparam int unsigned NumRounds = 14;
    localparam int unsigned NumRkeys  = 15;
    localparam int unsigned RkeyIdxW  = 4;

    typedef logic [7:0] t_sbox_table [256];

    localparam t_sbox_table SBOX = '{
        8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
        8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
        8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
        8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
        8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
        8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
        8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
        8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
        8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
        8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
        8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
        8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
        8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
        8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
        8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
        8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
    };

    // Config register indexes
    localparam logic [2:0] REG_KEY0   = 3'd0;
    localparam logic [2:0] REG_KEY1   = 3'd1;
    localparam logic [2:0] REG_KEY2   = 3'd2;
    localparam logic [2:0] REG_KEY3   = 3'd3;
    localparam logic [2:0] REG_LOCAL  = 3'd4;
    localparam logic [2:0] REG_REMOTE = 3'd5;

    // Controller -> datapath commands
    typedef struct packed {
        logic                load_in;    // capture request, set up counter block
        logic                key_init;   // load key halves into expansion regs
        logic                key_step;   // one expansion step (two round keys, one on the last step)
        logic                enc_start;  // whitening with round key 0
        logic                enc_round;  // one AES round
        logic                finish;     // form result, advance counter
        logic [RkeyIdxW-1:0] round;      // round number for enc_round / key_step
    } t_dp_cmd;

    function automatic logic [7:0] xtime(input logic [7:0] b);
        xtime = {b[6:0], 1'b0} ^ (b[7] ? 8'h1b : 8'h00);
    endfunction

    function automatic logic [31:0] sub_word(input logic [31:0] w);
        sub_word = {SBOX[w[31:24]], SBOX[w[23:16]], SBOX[w[15:8]], SBOX[w[7:0]]};
    endfunction

endpackage
`default_nettype wire

[rtl/aesctr_ctrl.sv]
`default_nettype none
module aesctr_ctrl
    import aesctr_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_in_fire,
    input  wire logic    i_first,
    input  wire logic    i_out_free,
    output logic         o_busy,
    output t_dp_cmd      o_cmd
);

    typedef enum logic [2:0] {S_IDLE, S_KINIT, S_KEXP, S_START, S_ROUND, S_DONE} t_state;

    t_state              r_state, n_state;
    logic [RkeyIdxW-1:0] r_cnt, n_cnt;

    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        o_cmd   = '0;
        o_cmd.round = r_cnt;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_fire) begin
                    o_cmd.load_in = 1'b1;
                    n_state = i_first ? S_KINIT : S_START;
                end
            end
            S_KINIT: begin
                o_cmd.key_init = 1'b1;
                n_cnt   = RkeyIdxW'(1);
                n_state = S_KEXP;
            end
            S_KEXP: begin
                // seven steps, two round keys each but one on the last
                o_cmd.key_step = 1'b1;
                n_cnt = r_cnt + RkeyIdxW'(1);
                if (r_cnt == RkeyIdxW'(7)) n_state = S_START;
            end
            S_START: begin
                o_cmd.enc_start = 1'b1;
                n_cnt   = RkeyIdxW'(1);
                n_state = S_ROUND;
            end
            S_ROUND: begin
                o_cmd.enc_round = 1'b1;
                n_cnt = r_cnt + RkeyIdxW'(1);
                if (r_cnt == RkeyIdxW'(NumRounds)) n_state = S_DONE;
            end
            S_DONE: begin
                if (i_out_free) begin
                    o_cmd.finish = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

    assign o_busy = (r_state != S_IDLE);

endmodule
`default_nettype wire

[rtl/aesctr_dpath.sv]
`default_nettype none
`include "assert_macros.svh"
module aesctr_dpath
    import aesctr_pkg::*;
(
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire t_dp_cmd       i_cmd,
    input  wire logic [255:0]  i_key,
    input  wire logic [15:0]   i_local,
    input  wire logic [15:0]   i_remote,
    input  wire logic          i_first,
    input  wire logic [15:0]   i_seq,
    input  wire logic          i_use_key,
    input  wire logic          i_invert,
    input  wire logic [63:0]   i_data_high,
    input  wire logic [63:0]   i_data_low,
    input  wire logic [4:0]    i_count,
    output logic               o_valid,
    input  wire logic          i_out_ready,
    output logic [63:0]        o_result_high,
    output logic [63:0]        o_result_low,
    output logic [4:0]         o_result_count
);

    logic [31:0]  r_nonce, r_ctr;
    logic         r_use_key;
    logic [127:0] r_data;
    logic [4:0]   r_count;
    logic [127:0] r_state;
    logic [255:0] r_kexp;      // last two round keys during expansion
    logic [7:0]   r_rcon;
    logic [127:0] r_rk_mem [NumRkeys];
    logic         r_out_valid;
    logic [127:0] r_res;
    logic [4:0]   r_res_count;

    // key expansion step: from keys (2i-2, 2i-1) derive (2i, 2i+1)
    logic [127:0] rk_a, rk_b, rk_na, rk_nb;
    logic [31:0]  ta0, ta1, ta2, ta3, tb0, tb1, tb2, tb3, t_rot;
    always_comb begin
        rk_a  = r_kexp[255:128];
        rk_b  = r_kexp[127:0];
        t_rot = sub_word({rk_b[23:0], rk_b[31:24]}) ^ {r_rcon, 24'h0};
        ta0 = rk_a[127:96] ^ t_rot;
        ta1 = rk_a[95:64]  ^ ta0;
        ta2 = rk_a[63:32]  ^ ta1;
        ta3 = rk_a[31:0]   ^ ta2;
        tb0 = rk_b[127:96] ^ sub_word(ta3);
        tb1 = rk_b[95:64]  ^ tb0;
        tb2 = rk_b[63:32]  ^ tb1;
        tb3 = rk_b[31:0]   ^ tb2;
        rk_na = {ta0, ta1, ta2, ta3};
        rk_nb = {tb0, tb1, tb2, tb3};
    end

    // one AES round on the state
    logic [7:0]   sb [16];
    logic [7:0]   mc [16];
    logic [127:0] round_out;
    always_comb begin
        for (int c = 0; c < 4; c++) begin
            for (int i = 0; i < 4; i++) begin
                sb[4*c+i] = SBOX[r_state[127-8*(4*((c+i)%4)+i) -: 8]];
            end
        end
        for (int c = 0; c < 4; c++) begin
            logic [7:0] all;
            all = sb[4*c] ^ sb[4*c+1] ^ sb[4*c+2] ^ sb[4*c+3];
            mc[4*c]   = sb[4*c]   ^ all ^ xtime(sb[4*c]   ^ sb[4*c+1]);
            mc[4*c+1] = sb[4*c+1] ^ all ^ xtime(sb[4*c+1] ^ sb[4*c+2]);
            mc[4*c+2] = sb[4*c+2] ^ all ^ xtime(sb[4*c+2] ^ sb[4*c+3]);
            mc[4*c+3] = sb[4*c+3] ^ all ^ xtime(sb[4*c+3] ^ sb[4*c]);
        end
        for (int j = 0; j < 16; j++) begin
            round_out[127-8*j -: 8] =
                (i_cmd.round == RkeyIdxW'(NumRounds)) ? sb[j] : mc[j];
        end
    end

    // byte mask from count (over sixteen means sixteen)
    logic [127:0] mask, ks_x;
    always_comb begin
        for (int j = 0; j < 16; j++) begin
            mask[127-8*j -: 8] = (5'(j) < r_count) ? 8'hff : 8'h00;
        end
        ks_x = (r_state ^ r_data) & mask;
    end

    // round key store: written during expansion, read during encryption
    always_ff @(posedge i_clk) begin
        if (i_cmd.key_init) begin
            r_rk_mem[0] <= i_key[255:128] & {128{r_use_key}};
            r_rk_mem[1] <= i_key[127:0]   & {128{r_use_key}};
        end else if (i_cmd.key_step) begin
            r_rk_mem[RkeyIdxW'({i_cmd.round, 1'b0})] <= rk_na;
            if (i_cmd.round != RkeyIdxW'(7))
                r_rk_mem[RkeyIdxW'({i_cmd.round, 1'b1})] <= rk_nb;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_data    <= {i_data_high, i_data_low};
            r_count   <= i_count;
            r_use_key <= i_use_key;
        end
        if (i_cmd.key_init) begin
            r_kexp <= i_key & {256{r_use_key}};
            r_rcon <= 8'h01;
        end else if (i_cmd.key_step) begin
            r_kexp <= {rk_na, rk_nb};
            r_rcon <= xtime(r_rcon);
        end
        if (i_cmd.enc_start) begin
            r_state <= {r_nonce, r_nonce, 32'h0, r_ctr} ^ r_rk_mem[0];
        end else if (i_cmd.enc_round) begin
            r_state <= round_out ^ r_rk_mem[i_cmd.round];
        end
        if (i_cmd.finish) begin
            r_res       <= ks_x;
            r_res_count <= r_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_nonce     <= '0;
            r_ctr       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.load_in && i_first) begin
                r_nonce <= (i_use_key ? {i_local, i_remote} : 32'h0) ^ {32{i_invert}};
                r_ctr   <= {i_seq, 16'h0};
            end
            if (i_cmd.finish) begin
                r_ctr       <= r_ctr + 32'd1;
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_valid        = r_out_valid;
    assign o_result_high  = r_res[127:64];
    assign o_result_low   = r_res[63:0];
    assign o_result_count = r_res_count;

    `ASSERT_NEXT(a_ctr_adv, i_clk, i_rst_n, i_cmd.finish, r_ctr == $past(r_ctr) + 32'd1, "counter did not advance")
    `ASSERT_IMPL(a_one_cmd, i_clk, i_rst_n, 1'b1, $onehot0({i_cmd.load_in, i_cmd.key_init, i_cmd.key_step, i_cmd.enc_start, i_cmd.enc_round, i_cmd.finish}), "overlapping datapath commands")
    `ASSERT_IMPL(a_fin_free, i_clk, i_rst_n, i_cmd.finish, !r_out_valid || i_out_ready, "result overwritten")

endmodule
`default_nettype wire

[rtl/aes256_counter_mode_packet_crypt_core.sv]
`default_nettype none
// AES-256 counter-mode packet crypt. Each request is one 16-byte block; the result is the block
// XORed with the AES-256 encryption of the counter block {nonce, nonce, 0, counter}, bytes past
// byte_count forced to zero. A first block expands the key (the configured key, or zeros when
// use_key is low) and rebuilds the nonce and counter, adding to the per-block cost. A block
// passes through accept, whitening, fourteen rounds and finish on the single shared round unit,
// a first block adding key expansion before whitening. The result sits in an output register, so
// the next request is taken as soon as the previous one is finished, even if it has not been
// drained yet -- finishing then waits until the output register frees. Configuration takes effect
// at the next first block and must be written only while idle; the block does not enforce this.
module aes256_counter_mode_packet_crypt_core
    import aesctr_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic [2:0]  i_cfg_index,
    input  wire logic [63:0] i_cfg_data,
    input  wire logic        i_valid,
    output logic             o_ready,
    input  wire logic        i_first_block,
    input  wire logic [15:0] i_packet_sequence,
    input  wire logic        i_use_key,
    input  wire logic        i_invert_nonce,
    input  wire logic [63:0] i_data_high,
    input  wire logic [63:0] i_data_low,
    input  wire logic [4:0]  i_byte_count,
    output logic             o_valid,
    input  wire logic        i_ready,
    output logic [63:0]      o_result_high,
    output logic [63:0]      o_result_low,
    output logic [4:0]       o_result_count
);

    logic [255:0] r_key;
    logic [15:0]  r_local, r_remote;
    logic         busy, in_fire;
    t_dp_cmd      cmd;

    // config always accepted; unknown indexes dropped
    assign o_cfg_ready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key    <= '0;
            r_local  <= '0;
            r_remote <= '0;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                REG_KEY0:   r_key[255:192] <= i_cfg_data;
                REG_KEY1:   r_key[191:128] <= i_cfg_data;
                REG_KEY2:   r_key[127:64]  <= i_cfg_data;
                REG_KEY3:   r_key[63:0]    <= i_cfg_data;
                REG_LOCAL:  r_local        <= i_cfg_data[15:0];
                REG_REMOTE: r_remote       <= i_cfg_data[15:0];
                default: ;
            endcase
        end
    end

    assign o_ready = !busy;
    assign in_fire = i_valid && o_ready;

    aesctr_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_fire  (in_fire),
        .i_first    (i_first_block),
        .i_out_free (!o_valid || i_ready),
        .o_busy     (busy),
        .o_cmd      (cmd)
    );

    aesctr_dpath u_dpath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .i_key          (r_key),
        .i_local        (r_local),
        .i_remote       (r_remote),
        .i_first        (i_first_block),
        .i_seq          (i_packet_sequence),
        .i_use_key      (i_use_key),
        .i_invert       (i_invert_nonce),
        .i_data_high    (i_data_high),
        .i_data_low     (i_data_low),
        .i_count        (i_byte_count),
        .o_valid        (o_valid),
        .i_out_ready    (i_ready),
        .o_result_high  (o_result_high),
        .o_result_low   (o_result_low),
        .o_result_count (o_result_count)
    );

endmodule
`default_nettype wire
